### hdl/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor line editor package
// Shared constants, key codes, state encoding and control structs.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int LINE_LEN_DEF = 64;
   localparam int CHAR_W       = 8;

   localparam logic [CHAR_W-1:0] KEY_DELETE = 8'h2D;
   localparam logic [CHAR_W-1:0] KEY_HOME   = 8'h5B;
   localparam logic [CHAR_W-1:0] KEY_END    = 8'h5D;
   localparam logic [CHAR_W-1:0] KEY_LEFT   = 8'h3C;
   localparam logic [CHAR_W-1:0] KEY_RIGHT  = 8'h3E;
   localparam logic [CHAR_W-1:0] KEY_NL     = 8'h0A;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SHIFT = 5'b00010,
      ST_PUT   = 5'b00100,
      ST_DUMP  = 5'b01000,
      ST_EMPTY = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic last;
      logic empty;
      logic ovf;
   } rsp_load_type;

   typedef struct packed {
      logic rd_issue;
      logic rd_pend;
   } ctrl_stat_type;

endpackage

### hdl/cle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor line editor channels
// Valid/ready channels for input bytes and output characters.
// ----------------------------------------------------------------------------
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;
   logic       empty_line;
   logic       overflowed;

   modport source (output valid, output out_char, output last, output empty_line,
                   output overflowed, input ready);
   modport sink (input valid, input out_char, input last, input empty_line,
                 input overflowed, output ready);
endinterface

### hdl/cle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor line editor RAM
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor line editor control
// Holds length, cursor and overflow flag, and sequences cell shifts and
// line dumps through the cell memory.
// ----------------------------------------------------------------------------
module cle_ctrl import cle_pkg::*; #(
   parameter int LINE_LEN = LINE_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   cle_req_if.sink                     req_if,
   input  logic                        rsp_free,
   output rsp_load_type                rsp_load,
   output ctrl_stat_type               stat,
   output logic                        mem_we,
   output logic [$clog2(LINE_LEN)-1:0] mem_wa,
   output logic [CHAR_W-1:0]           mem_wd,
   output logic [$clog2(LINE_LEN)-1:0] mem_ra,
   input  logic [CHAR_W-1:0]           mem_rd
);

   localparam int AW = $clog2(LINE_LEN);
   localparam int CW = $clog2(LINE_LEN + 1);
   localparam logic [CW-1:0] LEN_MAX = CW'(LINE_LEN);

   state_type       state_ff, state_in;
   logic [CW-1:0]   len_ff, len_in;
   logic [CW-1:0]   cur_ff, cur_in;
   logic            ovf_ff, ovf_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            pend_ff, pend_in;
   logic            pend_last_ff, pend_last_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   wa_ff, wa_in;
   logic [AW-1:0]   put_ff, put_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic            ins_ff, ins_in;
   logic            accept;
   logic            rd_issue;
   logic [CW-1:0]   tail;
   logic [CW-1:0]   len_m1;

   assign accept = req_if.valid && req_if.ready;
   assign tail   = len_ff - cur_ff;
   assign len_m1 = len_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      idx_in       = idx_ff;
      wa_in        = wa_ff;
      put_in       = put_ff;
      char_in      = char_ff;
      ins_in       = ins_ff;
      req_if.ready = (state_ff == ST_IDLE);
      mem_we       = 1'b0;
      mem_wa       = put_ff;
      mem_wd       = char_ff;
      mem_ra       = idx_ff;
      rd_issue     = 1'b0;
      rsp_load     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_if.ch)
                  KEY_NL: begin
                     if (len_ff == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        cnt_in   = len_ff;
                        state_in = ST_DUMP;
                     end
                  end
                  KEY_DELETE: begin
                     if (cur_ff != '0) begin
                        len_in = len_ff - 1'b1;
                        cur_in = cur_ff - 1'b1;
                        cnt_in = tail;
                        idx_in = cur_ff[AW-1:0];
                        ins_in = 1'b0;
                        if (tail != '0) begin
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  KEY_HOME: begin
                     cur_in = '0;
                  end
                  KEY_END: begin
                     cur_in = len_ff;
                  end
                  KEY_LEFT: begin
                     if (cur_ff != '0) begin
                        cur_in = cur_ff - 1'b1;
                     end
                  end
                  KEY_RIGHT: begin
                     if (cur_ff != len_ff) begin
                        cur_in = cur_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (len_ff != LEN_MAX) begin
                        len_in  = len_ff + 1'b1;
                        cur_in  = cur_ff + 1'b1;
                        char_in = req_if.ch;
                        put_in  = cur_ff[AW-1:0];
                        if (tail == '0) begin
                           mem_we = 1'b1;
                           mem_wa = cur_ff[AW-1:0];
                           mem_wd = req_if.ch;
                        end else begin
                           cnt_in   = tail;
                           idx_in   = len_m1[AW-1:0];
                           ins_in   = 1'b1;
                           state_in = ST_SHIFT;
                        end
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = wa_ff;
               mem_wd = mem_rd;
            end
            if (cnt_ff != '0) begin
               rd_issue = 1'b1;
               pend_in  = 1'b1;
               cnt_in   = cnt_ff - 1'b1;
               if (ins_ff) begin
                  wa_in  = idx_ff + 1'b1;
                  idx_in = idx_ff - 1'b1;
               end else begin
                  wa_in  = idx_ff - 1'b1;
                  idx_in = idx_ff + 1'b1;
               end
            end else if (pend_ff) begin
               state_in = ins_ff ? ST_PUT : ST_IDLE;
            end
         end
         ST_PUT: begin
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DUMP: begin
            if (pend_ff) begin
               rsp_load.load  = 1'b1;
               rsp_load.last  = pend_last_ff;
               rsp_load.empty = 1'b0;
               rsp_load.ovf   = ovf_ff;
               if (pend_last_ff) begin
                  len_in   = '0;
                  cur_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
            if (cnt_ff != '0 && !pend_ff && rsp_free) begin
               rd_issue     = 1'b1;
               pend_in      = 1'b1;
               pend_last_in = (cnt_ff == CW'(1));
               cnt_in       = cnt_ff - 1'b1;
               idx_in       = idx_ff + 1'b1;
            end
         end
         ST_EMPTY: begin
            if (rsp_free) begin
               rsp_load.load  = 1'b1;
               rsp_load.last  = 1'b1;
               rsp_load.empty = 1'b1;
               rsp_load.ovf   = ovf_ff;
               len_in         = '0;
               cur_in         = '0;
               ovf_in         = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         cur_ff   <= '0;
         ovf_ff   <= 1'b0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         cur_ff   <= cur_in;
         ovf_ff   <= ovf_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      idx_ff       <= idx_in;
      wa_ff        <= wa_in;
      put_ff       <= put_in;
      char_ff      <= char_in;
      ins_ff       <= ins_in;
   end

   assign stat.rd_issue = rd_issue;
   assign stat.rd_pend  = pend_ff;

endmodule

### hdl/cle_rsp_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor line editor output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module cle_rsp_stage import cle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  rsp_load_type      rsp_load,
   input  logic [CHAR_W-1:0] mem_rd,
   output logic              rsp_free,
   cle_rsp_if.source         rsp_if
);

   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic              empty_ff;
   logic              ovf_ff;

   assign rsp_free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_load.load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         char_ff  <= rsp_load.empty ? '0 : mem_rd;
         last_ff  <= rsp_load.last;
         empty_ff <= rsp_load.empty;
         ovf_ff   <= rsp_load.ovf;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.out_char   = char_ff;
   assign rsp_if.last       = last_ff;
   assign rsp_if.empty_line = empty_ff;
   assign rsp_if.overflowed = ovf_ff;

endmodule

### hdl/cursor_line_editor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor line editor core
// One-line text editor with a cursor, fed one byte per transaction.
//
// The req channel carries one byte per transaction: a command ('-', '[', ']',
// '<', '>'), a newline, or text to insert at the cursor. The rsp channel
// returns the line on a newline, one character per transaction from left to
// right, with last on the final one; an empty line gives a single result
// with empty_line set. overflowed reports a dropped insert since the last
// newline. The characters sit in a single-port-write memory with a
// registered read, so shifts and dumps go one cell per memory access.
// Cursor moves and edits at the end of the line need no shift. An insert
// ahead of the cursor tail shifts the tail right and then writes the byte;
// a delete ahead of the tail shifts it left. A newline reads each character
// and loads it into the output register before the next read is issued.
// Reset empties the line and clears the flag; cells stay unwritten until
// used. A stalled receiver holds the output register and pauses the dump;
// edits keep being taken while the last result of a line waits.
// ----------------------------------------------------------------------------
module cursor_line_editor_core import cle_pkg::*; #(
   parameter int LINE_LEN = LINE_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cle_req_if.sink   req_if,
   cle_rsp_if.source rsp_if
);

   localparam int AW = $clog2(LINE_LEN);

   rsp_load_type      rsp_load;
   ctrl_stat_type     ctrl_stat;
   logic              rsp_free;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CHAR_W-1:0] mem_wd;
   logic [AW-1:0]     mem_ra;
   logic [CHAR_W-1:0] mem_rd;

   cle_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(LINE_LEN)
   ) u_cells (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_wa),
      .wr_data(mem_wd),
      .rd_addr(mem_ra),
      .rd_data(mem_rd)
   );

   cle_ctrl #(
      .LINE_LEN(LINE_LEN)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_free(rsp_free),
      .rsp_load(rsp_load),
      .stat    (ctrl_stat),
      .mem_we  (mem_we),
      .mem_wa  (mem_wa),
      .mem_wd  (mem_wd),
      .mem_ra  (mem_ra),
      .mem_rd  (mem_rd)
   );

   cle_rsp_stage u_rsp (
      .clock   (clock),
      .reset   (reset),
      .rsp_load(rsp_load),
      .mem_rd  (mem_rd),
      .rsp_free(rsp_free),
      .rsp_if  (rsp_if)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.empty_line |-> rsp_if.last)
      else $error("Empty-line result without last.");

   a_no_accept_in_flight: assert property (@(posedge clock) disable iff (reset)
      ctrl_stat.rd_pend |-> !req_if.ready)
      else $error("Input accepted while a memory read is in flight.");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      mem_we && ctrl_stat.rd_issue |-> mem_wa != mem_ra)
      else $error("Memory read and write hit the same cell.");

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load.load |-> !rsp_if.valid || $past(rsp_if.ready) || rsp_if.ready)
      else $error("Result loaded over a transaction not yet taken.");

endmodule

### test/cursor_line_editor_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor line editor core testbench
// Streams edit keys, text bytes and newlines into the core and checks every
// dumped character against a behavioral copy of the line buffer and cursor.
// A short directed sequence covers the edge cases of each command. Random
// lines follow: ordinary edits, overfilled lines, lines deleted down to
// nothing and plain noise. The sender works in bursts and the receiver
// stalls on changing patterns.
// ----------------------------------------------------------------------------
module cursor_line_editor_core_test;
   import cle_pkg::*;

   localparam int LINE_LEN    = LINE_LEN_DEF;
   localparam int RANDOM_KEYS = 480;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 3 * LINE_LEN;

   typedef struct packed {
      logic [7:0] ch;
      logic       hold;
   } key_item_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic       empty_line;
      logic       overflowed;
   } line_char_type;

   logic clock;
   logic reset;

   cle_req_if req_bus ();
   cle_rsp_if rsp_bus ();

   cursor_line_editor_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   key_item_type  key_queue[$];
   line_char_type chars_due[$];
   line_char_type due;

   logic [7:0] line_text[LINE_LEN];
   int         line_len;
   int         cursor;
   logic       dropped_insert;

   bit          line_drained;
   int          failures;
   int          burst_left;
   int          gap_left;
   int          stall_mode;
   int          stall_left;
   int unsigned beat;
   int          idle_cycles;

   always #5 clock = ~clock;

   function automatic logic [7:0] pick_command(input bit with_delete);
      case ($urandom_range(with_delete ? 0 : 1, 4))
         0: return KEY_DELETE;
         1: return KEY_HOME;
         2: return KEY_END;
         3: return KEY_LEFT;
         default: return KEY_RIGHT;
      endcase
   endfunction

   function automatic logic [7:0] random_text();
      logic [7:0] r;
      do begin
         r = 8'($urandom_range(0, 255));
      end while (r == KEY_DELETE || r == KEY_HOME || r == KEY_END ||
                 r == KEY_LEFT || r == KEY_RIGHT || r == KEY_NL);
      return r;
   endfunction

   function automatic void queue_key(input logic [7:0] ch, input logic hold);
      key_queue.push_back('{ch, hold});
   endfunction

   // Applies one key to the line and queues the characters that a newline dumps.
   function automatic void edit_line(input logic [7:0] key);
      int k;
      case (key)
         KEY_NL: begin
            if (line_len == 0) begin
               chars_due.push_back('{8'h00, 1'b1, 1'b1, dropped_insert});
            end else begin
               for (k = 0; k < line_len; k++)
                  chars_due.push_back('{line_text[k], k == line_len - 1, 1'b0,
                                        dropped_insert});
            end
            line_len       = 0;
            cursor         = 0;
            dropped_insert = 1'b0;
         end
         KEY_DELETE: begin
            if (cursor > 0) begin
               for (k = cursor; k < line_len; k++)
                  line_text[k-1] = line_text[k];
               line_len--;
               cursor--;
            end
         end
         KEY_HOME: cursor = 0;
         KEY_END: cursor = line_len;
         KEY_LEFT: begin
            if (cursor > 0) cursor--;
         end
         KEY_RIGHT: begin
            if (cursor < line_len) cursor++;
         end
         default: begin
            if (line_len < LINE_LEN) begin
               for (k = line_len; k > cursor; k--)
                  line_text[k] = line_text[k-1];
               line_text[cursor] = key;
               line_len++;
               cursor++;
            end else begin
               dropped_insert = 1'b1;
            end
         end
      endcase
   endfunction

   // Driver: loads the next key once the previous transaction is done.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.ch    <= 8'h00;
         burst_left    = $urandom_range(1, 32);
         gap_left      = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (key_queue.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (key_queue[0].hold && (req_bus.valid || !line_drained)) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid <= 1'b1;
            req_bus.ch    <= key_queue[0].ch;
            void'(key_queue.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                        : $urandom_range(0, 3);
            end
         end
      end
   end

   // Monitor: checks dumped characters, then updates the line with accepted keys.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         line_drained  <= 1'b1;
         stall_mode    = 0;
         stall_left    = 0;
         beat          = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (chars_due.size() == 0) begin
               $error("Unexpected result: out_char %h last %b empty_line %b",
                      rsp_bus.out_char, rsp_bus.last, rsp_bus.empty_line);
               failures++;
            end else begin
               due = chars_due.pop_front();
               if (!due.empty_line && rsp_bus.out_char !== due.out_char) begin
                  $error("out_char: expected %h, actual %h", due.out_char,
                         rsp_bus.out_char);
                  failures++;
               end
               if (rsp_bus.last !== due.last) begin
                  $error("last: expected %b, actual %b", due.last, rsp_bus.last);
                  failures++;
               end
               if (rsp_bus.empty_line !== due.empty_line) begin
                  $error("empty_line: expected %b, actual %b", due.empty_line,
                         rsp_bus.empty_line);
                  failures++;
               end
               if (rsp_bus.overflowed !== due.overflowed) begin
                  $error("overflowed: expected %b, actual %b", due.overflowed,
                         rsp_bus.overflowed);
                  failures++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            edit_line(req_bus.ch);
         line_drained <= (chars_due.size() == 0);

         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         beat++;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            3: rsp_bus.ready <= ((beat % 7) < 3);
            default: rsp_bus.ready <= ((beat % 32) < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) ||
                   (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n;
      int k;
      int kind;
      logic hold;

      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.ch     = 8'h00;
      rsp_bus.ready  = 1'b0;
      failures       = 0;
      line_len       = 0;
      cursor         = 0;
      dropped_insert = 1'b0;

      // Empty line, then every command with nothing to act on.
      queue_key(KEY_NL, 1'b0);
      queue_key(KEY_DELETE, 1'b0);
      queue_key(KEY_LEFT, 1'b0);
      queue_key(KEY_RIGHT, 1'b0);
      queue_key(KEY_HOME, 1'b0);
      queue_key(KEY_END, 1'b0);
      // Extreme text bytes, a delete in the middle and a delete at the start.
      queue_key(8'h00, 1'b0);
      queue_key(8'hFF, 1'b0);
      queue_key(8'h80, 1'b0);
      queue_key(8'h61, 1'b0);
      queue_key(KEY_LEFT, 1'b0);
      queue_key(KEY_LEFT, 1'b0);
      queue_key(KEY_DELETE, 1'b0);
      queue_key(KEY_HOME, 1'b0);
      queue_key(KEY_DELETE, 1'b0);
      // Insert ahead of the tail, a move past the end and a delete of the last character.
      queue_key(KEY_RIGHT, 1'b0);
      queue_key(8'h62, 1'b0);
      queue_key(KEY_END, 1'b0);
      queue_key(KEY_RIGHT, 1'b0);
      queue_key(KEY_DELETE, 1'b0);
      queue_key(KEY_NL, 1'b0);
      // A line deleted down to nothing, sent only after the previous dump is out.
      queue_key(8'h78, 1'b1);
      queue_key(KEY_DELETE, 1'b0);
      queue_key(KEY_NL, 1'b0);

      n = key_queue.size() + RANDOM_KEYS;
      while (key_queue.size() < n) begin
         kind = $urandom_range(0, 19);
         hold = ($urandom_range(0, 9) == 0);
         if (kind == 0) begin
            // Overfilled line with cursor moves, so inserts land at both ends and inside.
            kind = 0;
            while (kind <= LINE_LEN) begin
               if ($urandom_range(0, 7) == 0) begin
                  queue_key(pick_command(1'b0), hold);
               end else begin
                  queue_key(random_text(), hold);
                  kind++;
               end
               hold = 1'b0;
            end
            queue_key(KEY_NL, 1'b0);
         end else if (kind == 1) begin
            for (k = 0; k < $urandom_range(3, 12); k++) begin
               queue_key(8'($urandom_range(0, 255)), hold);
               hold = 1'b0;
            end
         end else if (kind == 2) begin
            kind = $urandom_range(1, 6);
            for (k = 0; k < kind; k++) begin
               queue_key(random_text(), hold);
               hold = 1'b0;
            end
            queue_key(KEY_END, 1'b0);
            for (k = 0; k < kind + $urandom_range(0, 2); k++)
               queue_key(KEY_DELETE, 1'b0);
            queue_key(KEY_NL, 1'b0);
         end else begin
            for (k = 0; k < $urandom_range(0, 14); k++) begin
               queue_key(($urandom_range(0, 2) == 0) ? pick_command(1'b1) : random_text(),
                         hold);
               hold = 1'b0;
            end
            queue_key(KEY_NL, hold);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (key_queue.size() != 0 || req_bus.valid) @(negedge clock);
      while (chars_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
